// ----- design/evm_cbg_pkg.sv -----
// ----------------------------------------------------------------------------
// evm_cbg_pkg
// Types and constants for the EVM copy bounds and gas planning unit.
// ----------------------------------------------------------------------------
package evm_cbg_pkg;

  // Largest buffer index or length that a copy may use.
  localparam logic [63:0] BUFFER_LIMIT = 64'd4294967295;
  // Memory size in bytes that the expansion must stay below.
  localparam logic [63:0] MEMORY_LIMIT = 64'd33554432;
  // Smallest word count whose byte size reaches the memory limit.
  localparam logic [63:0] MEM_LIMIT_WORDS = (MEMORY_LIMIT + 64'd31) / 64'd32;

  localparam int IN_DATA_W  = 224;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 224;

  typedef enum logic [1:0] {
    CMD_CALLDATA = 2'd0,
    CMD_CODE     = 2'd1,
    CMD_RETURN   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ERR_OK         = 3'd0,
    ERR_BUFFER     = 3'd1,
    ERR_GAS        = 3'd2,
    ERR_MEM_LIMIT  = 3'd3,
    ERR_RETURN_OOB = 3'd4
  } err_code_t;

  // Work carried down the pipeline; each stage fills in its own fields.
  typedef struct packed {
    logic        rd;       // return data copy
    logic        zero;     // zero length request
    logic        ovf;      // offset or length beyond the buffer limit
    logic        grow;     // end of destination lies beyond current memory
    logic        rd_oob;   // return data range out of bounds
    logic [31:0] off;
    logic [31:0] len;
    logic [31:0] sstart;
    logic [31:0] avail;
    logic [31:0] copy;
    logic [31:0] pad;
    logic [25:0] cur;
    logic [63:0] gas;
    logic [28:0] nw;       // new memory size in words
    logic [20:0] cw;       // current memory size in words
    logic [27:0] cwl;      // copy length in words
    logic [29:0] cg;       // copy cost
    logic [57:0] sqn;
    logic [41:0] sqc;
    logic [49:0] costn;
    logic [33:0] costc;
    logic [49:0] cost;     // expansion cost
  } plan_t;

  // Result fields; the last member sits in the lowest bits of tdata.
  typedef struct packed {
    logic [31:0] pad_len;
    logic [31:0] copy_len;
    logic [31:0] src_start;
    logic [31:0] dest_start;
    logic [63:0] gas_charged;
    logic [25:0] new_mem_bytes;
    err_code_t   error_code;
  } result_t;

endpackage

// ----- design/evm_copy_bounds_and_gas_unit.sv -----
// ----------------------------------------------------------------------------
// evm_copy_bounds_and_gas_unit
// Bounds check, memory expansion cost and copy plan for one EVM copy.
// ----------------------------------------------------------------------------
// Path: an accepted transfer on the slave side passes through the stage
// registers s1 to s4 and then the output register before its result appears.
// Throughput: one instruction per cycle; the five register stages each take a
// new item whenever the stage after them is empty or moving.
// Reset: rst is synchronous and active high; it clears every valid bit, so
// the pipeline comes up empty. Payload registers are not reset.
module evm_copy_bounds_and_gas_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0 up: mem_offset[31:0], mem_offset_huge, length_req[31:0],
  // length_huge, src_index[31:0], src_index_huge, source_len[31:0],
  // current_mem_bytes[25:0], gas_left[63:0], three zero bits.
  input  logic [evm_cbg_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0 up: command[1:0].
  input  logic [evm_cbg_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Fields from bit 0 up: error_code[2:0], new_mem_bytes[25:0],
  // gas_charged[63:0], dest_start[31:0], src_start[31:0], copy_len[31:0],
  // pad_len[31:0], three zero bits.
  output logic [evm_cbg_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  import evm_cbg_pkg::*;

  // Input fields as they sit in tdata and tuser.
  logic [1:0]  command;
  logic [31:0] mem_offset;
  logic        mem_offset_huge;
  logic [31:0] length_req;
  logic        length_huge;
  logic [31:0] src_index;
  logic        src_index_huge;
  logic [31:0] source_len;
  logic [25:0] current_mem_bytes;
  logic [63:0] gas_left;

  assign command           = s_axis_tuser[1:0];
  assign mem_offset        = s_axis_tdata[31:0];
  assign mem_offset_huge   = s_axis_tdata[32];
  assign length_req        = s_axis_tdata[64:33];
  assign length_huge       = s_axis_tdata[65];
  assign src_index         = s_axis_tdata[97:66];
  assign src_index_huge    = s_axis_tdata[98];
  assign source_len        = s_axis_tdata[130:99];
  assign current_mem_bytes = s_axis_tdata[156:131];
  assign gas_left          = s_axis_tdata[220:157];

  // Pipeline registers. Stage 1 holds the bounds checks and word counts,
  // stage 2 the squares and the copy split, stage 3 the two size costs,
  // stage 4 the expansion cost, and the output register the final verdict.
  plan_t   s1, s2, s3, s4;
  plan_t   s1_next, s2_next, s3_next, s4_next;
  logic    v1, v2, v3, v4;
  result_t res, res_next;
  logic    res_valid;

  // A stage takes new data when it is empty or its content moves on.
  logic en1, en2, en3, en4, en_out;

  assign en_out = !res_valid || m_axis_tready;
  assign en4    = !v4 || en_out;
  assign en3    = !v3 || en4;
  assign en2    = !v2 || en3;
  assign en1    = !v1 || en2;

  assign s_axis_tready = en1;
  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {3'b000, res};

  // Stage 1: operand checks, destination end in words, source clamping.
  logic [32:0] need;
  logic [33:0] need_round;
  logic [32:0] len_round;
  logic [32:0] src_end;

  always_comb begin
    s1_next = '0;
    need       = {1'b0, mem_offset} + {1'b0, length_req};
    need_round = {1'b0, need} + 34'd31;
    len_round  = {1'b0, length_req} + 33'd31;
    src_end    = {1'b0, src_index} + {1'b0, length_req};

    s1_next.rd   = command[1];
    s1_next.zero = !length_huge && (length_req == '0);
    s1_next.ovf  = length_huge || (64'(length_req) > BUFFER_LIMIT) ||
                   mem_offset_huge || (64'(mem_offset) > BUFFER_LIMIT);
    s1_next.grow = need > 33'(current_mem_bytes);
    s1_next.off  = mem_offset;
    s1_next.len  = length_req;
    s1_next.cur  = current_mem_bytes;
    s1_next.gas  = gas_left;
    s1_next.nw   = need_round[33:5];
    s1_next.cw   = current_mem_bytes[25:5];
    s1_next.cwl  = len_round[32:5];

    // Return data must lie wholly inside the buffer, even for zero length.
    s1_next.rd_oob = command[1] &&
                     (src_index_huge || (src_index > source_len) ||
                      (src_end > {1'b0, source_len}));

    if (command[1]) begin
      s1_next.sstart = src_index;
    end else if (cmd_t'(command) == CMD_CODE) begin
      s1_next.sstart = (src_index_huge || (64'(src_index) > BUFFER_LIMIT)) ?
                       BUFFER_LIMIT[31:0] : src_index;
    end else begin
      s1_next.sstart = (src_index_huge || (src_index > source_len)) ?
                       source_len : src_index;
    end
    s1_next.avail = (s1_next.sstart < source_len) ? (source_len - s1_next.sstart) : '0;
  end

  // Stage 2: squares for both size costs, copy and pad split, copy cost.
  always_comb begin
    s2_next     = s1;
    s2_next.sqn = 58'(s1.nw) * 58'(s1.nw);
    s2_next.sqc = 42'(s1.cw) * 42'(s1.cw);
    s2_next.cg  = 30'(s1.cwl) * 30'd3;
    if (s1.rd) begin
      s2_next.copy = s1.len;
      s2_next.pad  = '0;
    end else begin
      s2_next.copy = (s1.len < s1.avail) ? s1.len : s1.avail;
      s2_next.pad  = s1.len - s2_next.copy;
    end
  end

  // Stage 3: cost of a size of w words is 3*w + w*w/512.
  always_comb begin
    s3_next       = s2;
    s3_next.costn = 50'(s2.nw) * 50'd3 + 50'(s2.sqn[57:9]);
    s3_next.costc = 34'(s2.cw) * 34'd3 + 34'(s2.sqc[41:9]);
  end

  // Stage 4: expansion cost is the difference of the two size costs.
  always_comb begin
    s4_next      = s3;
    s4_next.cost = s3.costn - 50'(s3.costc);
  end

  // Output stage: the checks are applied in the order of the instruction,
  // and each charge that succeeded stays even when a later check fails.
  logic        expand;
  logic [63:0] exp_cost;
  logic [63:0] total;
  logic        exp_short;
  logic        mem_over;

  always_comb begin
    expand    = !s4.zero && !s4.ovf && s4.grow;
    exp_cost  = expand ? 64'(s4.cost) : '0;
    total     = exp_cost + 64'(s4.cg);
    exp_short = 64'(s4.cost) > s4.gas;
    mem_over  = 64'(s4.nw) >= MEM_LIMIT_WORDS;

    res_next               = '0;
    res_next.new_mem_bytes = s4.cur;
    res_next.error_code    = ERR_OK;

    if (!s4.zero && s4.ovf) begin
      res_next.error_code = ERR_BUFFER;
    end else if (expand && exp_short) begin
      res_next.error_code = ERR_GAS;
    end else if (expand && mem_over) begin
      res_next.error_code  = ERR_MEM_LIMIT;
      res_next.gas_charged = exp_cost;
    end else begin
      if (expand) begin
        res_next.new_mem_bytes = 26'({s4.nw, 5'b00000});
      end
      if (s4.rd_oob) begin
        res_next.error_code  = ERR_RETURN_OOB;
        res_next.gas_charged = exp_cost;
      end else if (total > s4.gas) begin
        res_next.error_code  = ERR_GAS;
        res_next.gas_charged = exp_cost;
      end else begin
        res_next.gas_charged = total;
        res_next.dest_start  = s4.off;
        res_next.src_start   = s4.sstart;
        res_next.copy_len    = s4.copy;
        res_next.pad_len     = s4.pad;
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (en1) v1 <= s_axis_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en_out) res_valid <= v4;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en1) s1 <= s1_next;
    if (en2) s2 <= s2_next;
    if (en3) s3 <= s3_next;
    if (en4) s4 <= s4_next;
    if (en_out) res <= res_next;
  end

`ifndef NO_ASSERTIONS
  // The slave side only waits when the whole pipeline is full and blocked.
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while the pipeline could move");

  // An accepted transfer always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> v1)
    else $error("accepted transfer was lost at stage 1");

  // A failed instruction carries no copy plan.
  a_error_no_plan: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res.error_code != ERR_OK) |->
      (res.dest_start == '0 && res.src_start == '0 &&
       res.copy_len == '0 && res.pad_len == '0))
    else $error("copy plan present on an error result");

  // A buffer overflow charges nothing.
  a_overflow_free: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res.error_code == ERR_BUFFER) |-> (res.gas_charged == '0))
    else $error("gas charged on a buffer overflow");
`endif

endmodule

// ----- dv/evm_cbg_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// evm_cbg_tb_pkg
// Request layout, expected-plan calculator and result checker for the copy
// bounds and gas unit testbench.
// ----------------------------------------------------------------------------
package evm_cbg_tb_pkg;

  import evm_cbg_pkg::*;

  // Command 3 has bit 1 set and is handled as a return data copy.
  localparam logic [1:0] CMD_RETURN_ALIAS = CMD_RETURN | CMD_CODE;

  // Slave-side tdata layout; the last member sits in the lowest bits.
  typedef struct packed {
    logic [2:0]  unused;
    logic [63:0] gas_left;
    logic [25:0] current_mem_bytes;
    logic [31:0] source_len;
    logic        src_index_huge;
    logic [31:0] src_index;
    logic        length_huge;
    logic [31:0] length_req;
    logic        mem_offset_huge;
    logic [31:0] mem_offset;
  } copy_req_t;

  function automatic result_t unpack_result(logic [OUT_DATA_W-1:0] d);
    result_t r;
    r.error_code    = err_code_t'(d[2:0]);
    r.new_mem_bytes = d[28:3];
    r.gas_charged   = d[92:29];
    r.dest_start    = d[124:93];
    r.src_start     = d[156:125];
    r.copy_len      = d[188:157];
    r.pad_len       = d[220:189];
    return r;
  endfunction

  class copy_plan_scoreboard;
    result_t pending[$];
    int      failures;
    int      checked;
    int      outcome_count[5];

    function new();
      failures = 0;
      checked  = 0;
      foreach (outcome_count[i]) outcome_count[i] = 0;
    endfunction

    function logic [63:0] word_count(logic [63:0] bytes);
      return (bytes + 64'd31) / 64'd32;
    endfunction

    // Memory of w words costs 3 per word plus w squared over 512.
    function logic [63:0] mem_cost(logic [63:0] w);
      return 64'd3 * w + (w * w) / 64'd512;
    endfunction

    function result_t plan_copy(logic [1:0] cmd, copy_req_t r);
      logic [63:0] off, len, src, slen, cur;
      logic [63:0] gas_rest, charged, mem_bytes, need, nw, grow_cost;
      logic [63:0] size, avail, copy_cost, first, taken, zeros;
      logic        zero_len;
      err_code_t   err;
      result_t     res;
      off       = 64'(r.mem_offset);
      len       = 64'(r.length_req);
      src       = 64'(r.src_index);
      slen      = 64'(r.source_len);
      cur       = 64'(r.current_mem_bytes);
      err       = ERR_OK;
      mem_bytes = cur;
      charged   = '0;
      gas_rest  = r.gas_left;
      first     = '0;
      taken     = '0;
      zeros     = '0;
      zero_len  = !r.length_huge && (len == 64'd0);

      // A zero-length copy neither checks the offset nor grows memory.
      if (!zero_len) begin
        if (r.length_huge || len > BUFFER_LIMIT || r.mem_offset_huge ||
            off > BUFFER_LIMIT) begin
          err = ERR_BUFFER;
        end else begin
          need = off + len;
          if (need > cur) begin
            nw        = word_count(need);
            grow_cost = mem_cost(nw) - mem_cost(cur / 64'd32);
            if (grow_cost > gas_rest) begin
              err = ERR_GAS;
            end else begin
              gas_rest -= grow_cost;
              charged  += grow_cost;
              if (nw * 64'd32 >= MEMORY_LIMIT) err = ERR_MEM_LIMIT;
              else mem_bytes = nw * 64'd32;
            end
          end
        end
      end

      if (err == ERR_OK) begin
        size = zero_len ? 64'd0 : len;
        if (cmd[1]) begin
          if (r.src_index_huge || src > slen || src + size > slen) begin
            err = ERR_RETURN_OOB;
          end else begin
            first = src;
            taken = size;
          end
        end else if (cmd == CMD_CODE) begin
          first = r.src_index_huge ? BUFFER_LIMIT : src;
          if (first < slen) begin
            avail = slen - first;
            taken = (size < avail) ? size : avail;
          end
          zeros = size - taken;
        end else begin
          first = (r.src_index_huge || src > slen) ? slen : src;
          avail = slen - first;
          taken = (size < avail) ? size : avail;
          zeros = size - taken;
        end
        if (err == ERR_OK) begin
          copy_cost = word_count(size) * 64'd3;
          if (copy_cost > gas_rest) err = ERR_GAS;
          else charged += copy_cost;
        end
      end

      res.error_code    = err;
      res.new_mem_bytes = mem_bytes[25:0];
      res.gas_charged   = charged;
      res.dest_start    = (err == ERR_OK) ? off[31:0] : 32'd0;
      res.src_start     = (err == ERR_OK) ? first[31:0] : 32'd0;
      res.copy_len      = (err == ERR_OK) ? taken[31:0] : 32'd0;
      res.pad_len       = (err == ERR_OK) ? zeros[31:0] : 32'd0;
      return res;
    endfunction

    function void note_request(logic [1:0] cmd, copy_req_t r);
      result_t want;
      want = plan_copy(cmd, r);
      pending.push_back(want);
      outcome_count[int'(want.error_code)]++;
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("result transfer with no plan outstanding: error_code %0d",
               got.error_code);
        failures++;
        return;
      end
      want = pending.pop_front();
      checked++;
      compare_field("error_code", 64'(want.error_code), 64'(got.error_code));
      compare_field("new_mem_bytes", 64'(want.new_mem_bytes), 64'(got.new_mem_bytes));
      compare_field("gas_charged", want.gas_charged, got.gas_charged);
      compare_field("dest_start", 64'(want.dest_start), 64'(got.dest_start));
      compare_field("src_start", 64'(want.src_start), 64'(got.src_start));
      compare_field("copy_len", 64'(want.copy_len), 64'(got.copy_len));
      compare_field("pad_len", 64'(want.pad_len), 64'(got.pad_len));
    endfunction
  endclass

endpackage

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench for evm_copy_bounds_and_gas_unit. Directed copy plans cover the
// zero-length, overflow, out-of-gas, memory-limit and return-data corner
// cases; about 500 random plans follow. Every result transfer is checked
// field by field against a plan computed in the testbench, while both stream
// sides idle at random and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;

  import evm_cbg_pkg::*;
  import evm_cbg_tb_pkg::*;

  localparam logic [63:0] GAS_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] ALL32 = 32'hFFFF_FFFF;
  localparam int unsigned MEM_LIMIT_B = 32'(MEMORY_LIMIT);
  // The receiver stalls this long once, so the five-stage pipe fills up.
  localparam int LONG_HOLD_CYCLES = 80;
  // Cycles allowed after the last expected result for stray transfers.
  localparam int SETTLE_CYCLES = 30;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // Fields from bit 0 up: mem_offset, mem_offset_huge, length_req, length_huge,
  // src_index, src_index_huge, source_len, current_mem_bytes, gas_left.
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // Fields from bit 0 up: command.
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // Fields from bit 0 up: error_code, new_mem_bytes, gas_charged, dest_start,
  // src_start, copy_len, pad_len.
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Per-phase switches: when clear, that side never idles between transfers.
  bit sender_idle   = 1'b1;
  bit receiver_idle = 1'b1;
  bit long_hold_req = 1'b0;
  int input_stall_cycles = 0;

  copy_plan_scoreboard sb;

  evm_copy_bounds_and_gas_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop; a correct run needs well under a tenth of this.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  // Counts cycles in which the unit refuses an offered request.
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && !s_axis_tready) input_stall_cycles++;
  end

  function automatic copy_req_t copy_req(logic [31:0] off, logic off_h,
                                         logic [31:0] len, logic len_h,
                                         logic [31:0] src, logic src_h,
                                         logic [31:0] slen, logic [25:0] cur,
                                         logic [63:0] gas);
    copy_req_t r;
    r                   = '0;
    r.mem_offset        = off;
    r.mem_offset_huge   = off_h;
    r.length_req        = len;
    r.length_huge       = len_h;
    r.src_index         = src;
    r.src_index_huge    = src_h;
    r.source_len        = slen;
    r.current_mem_bytes = cur;
    r.gas_left          = gas;
    return r;
  endfunction

  // Random request. Most are plausible interpreter traffic with small sizes;
  // some sit near the memory limit and some are raw random bits. A quarter
  // get exactly the gas that the full plan needs, or one less, to land on
  // the out-of-gas boundaries.
  function automatic void draw_request(output logic [1:0] cmd, output copy_req_t r);
    int        kind;
    copy_req_t probe;
    result_t   full;
    kind = $urandom_range(0, 99);
    cmd  = ($urandom_range(0, 15) == 0) ? CMD_RETURN_ALIAS : 2'($urandom_range(0, 2));
    r    = '0;
    r.mem_offset_huge = ($urandom_range(0, 15) == 0);
    r.length_huge     = ($urandom_range(0, 15) == 0);
    r.src_index_huge  = ($urandom_range(0, 15) == 0);
    if (kind < 60) begin
      r.current_mem_bytes = 26'(32 * $urandom_range(0, 4096));
      r.mem_offset = $urandom_range(0, 32'(r.current_mem_bytes) + 8192);
      r.length_req = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, 4096);
      r.source_len = $urandom_range(0, 8192);
      r.src_index  = $urandom_range(0, r.source_len + 256);
      r.gas_left   = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 1000))
                                                 : 64'd1000000;
    end else if (kind < 80) begin
      r.current_mem_bytes = 26'(32 * $urandom_range(MEM_LIMIT_B / 32 - 64, MEM_LIMIT_B / 32));
      r.mem_offset = MEM_LIMIT_B - $urandom_range(0, 4096);
      r.length_req = $urandom_range(1, 4096);
      r.source_len = $urandom_range(0, 8192);
      r.src_index  = $urandom_range(0, r.source_len + 256);
      r.gas_left   = {$urandom, $urandom};
    end else begin
      r.current_mem_bytes = 26'($urandom_range(0, MEM_LIMIT_B));
      r.mem_offset = $urandom;
      r.length_req = $urandom;
      r.src_index  = $urandom;
      r.source_len = $urandom;
      r.gas_left   = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom}
                                                 : 64'($urandom_range(0, 100000));
    end
    if ($urandom_range(0, 3) == 0) begin
      probe          = r;
      probe.gas_left = GAS_MAX;
      full           = sb.plan_copy(cmd, probe);
      r.gas_left     = full.gas_charged - 64'($urandom_range(0, 1));
    end
  endfunction

  // Offers one request and returns once it has been accepted. tvalid stays
  // high afterwards, so back-to-back requests never drop it in between; it
  // is lowered only when the next request draws a gap.
  task automatic send_request(logic [1:0] cmd, copy_req_t r);
    int gap;
    gap = sender_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r;
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(cmd, r);
  endtask

  task automatic send_random(int count);
    logic [1:0] cmd;
    copy_req_t  r;
    for (int i = 0; i < count; i++) begin
      draw_request(cmd, r);
      send_request(cmd, r);
    end
  endtask

  // Result side. Before each transfer it either stalls for a drawn number of
  // cycles or, once on request, holds tready low for the long stretch. As
  // with tvalid, tready is only lowered when a stall actually follows.
  task automatic drain_results();
    int stall;
    forever begin
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
      end else begin
        stall = receiver_idle ? $urandom_range(0, 7) : 0;
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_result(unpack_result(m_axis_tdata));
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    fork
      drain_results();
    join_none

    // Zero length: the offset is ignored even when huge, and gas may be zero.
    send_request(CMD_CALLDATA, copy_req(ALL32, 1'b1, 32'd0, 1'b0, 32'd5, 1'b0,
                                        32'd10, 26'd0, 64'd0));
    // Zero length still fails a return data index past the end.
    send_request(CMD_RETURN, copy_req(32'd0, 1'b0, 32'd0, 1'b0, 32'd11, 1'b0,
                                      32'd10, 26'd64, 64'd100));
    // Huge length and huge offset are buffer overflows.
    send_request(CMD_CALLDATA, copy_req(32'd0, 1'b0, 32'd32, 1'b1, 32'd0, 1'b0,
                                        32'd100, 26'd0, GAS_MAX));
    send_request(CMD_CODE, copy_req(32'd0, 1'b1, 32'd32, 1'b0, 32'd0, 1'b0,
                                    32'd100, 26'd0, GAS_MAX));
    // Expansion that the gas cannot pay for.
    send_request(CMD_CALLDATA, copy_req(32'd1000000, 1'b0, 32'd32, 1'b0, 32'd0, 1'b0,
                                        32'd64, 26'd0, 64'd100));
    // New size lands exactly on the memory limit, then one word below it.
    send_request(CMD_CALLDATA, copy_req(MEM_LIMIT_B - 32, 1'b0, 32'd32, 1'b0, 32'd0,
                                        1'b0, 32'd64, 26'd0, GAS_MAX));
    send_request(CMD_CALLDATA, copy_req(MEM_LIMIT_B - 64, 1'b0, 32'd32, 1'b0, 32'd0,
                                        1'b0, 32'd64, 26'd0, GAS_MAX));
    // Calldata: partial copy with padding, index past the end, huge index.
    send_request(CMD_CALLDATA, copy_req(32'd0, 1'b0, 32'd100, 1'b0, 32'd40, 1'b0,
                                        32'd64, 26'd0, GAS_MAX));
    send_request(CMD_CALLDATA, copy_req(32'd0, 1'b0, 32'd10, 1'b0, 32'd200, 1'b0,
                                        32'd64, 26'd32, GAS_MAX));
    send_request(CMD_CALLDATA, copy_req(32'd16, 1'b0, 32'd10, 1'b0, 32'd3, 1'b1,
                                        32'd64, 26'd32, GAS_MAX));
    // Code: partial copy, huge index clamps to the buffer limit, index at end.
    send_request(CMD_CODE, copy_req(32'd0, 1'b0, 32'd50, 1'b0, 32'd10, 1'b0,
                                    32'd30, 26'd64, GAS_MAX));
    send_request(CMD_CODE, copy_req(32'd0, 1'b0, 32'd50, 1'b0, 32'd10, 1'b1,
                                    32'd30, 26'd64, GAS_MAX));
    send_request(CMD_CODE, copy_req(32'd0, 1'b0, 32'd8, 1'b0, ALL32, 1'b0,
                                    ALL32, 26'd64, GAS_MAX));
    // Return data: exact fit, one byte over, huge index.
    send_request(CMD_RETURN, copy_req(32'd0, 1'b0, 32'd16, 1'b0, 32'd4, 1'b0,
                                      32'd20, 26'd32, GAS_MAX));
    send_request(CMD_RETURN, copy_req(32'd0, 1'b0, 32'd16, 1'b0, 32'd5, 1'b0,
                                      32'd20, 26'd32, GAS_MAX));
    send_request(CMD_RETURN, copy_req(32'd0, 1'b0, 32'd16, 1'b0, 32'd0, 1'b1,
                                      32'd20, 26'd32, GAS_MAX));
    // Command three behaves as a return data copy.
    send_request(CMD_RETURN_ALIAS, copy_req(32'd8, 1'b0, 32'd16, 1'b0, 32'd4, 1'b0,
                                            32'd20, 26'd32, GAS_MAX));
    send_request(CMD_RETURN_ALIAS, copy_req(32'd8, 1'b0, 32'd16, 1'b0, 32'd21, 1'b0,
                                            32'd20, 26'd32, GAS_MAX));
    // Expansion fits but the copy charge does not; expansion stays charged.
    send_request(CMD_CALLDATA, copy_req(32'd0, 1'b0, 32'd32, 1'b0, 32'd0, 1'b0,
                                        32'd64, 26'd0, 64'd4));
    // Gas exactly covers the copy charge with no growth.
    send_request(CMD_CODE, copy_req(32'd0, 1'b0, 32'd64, 1'b0, 32'd0, 1'b0,
                                    32'd64, 26'd64, 64'd6));
    // Full memory, no growth, no gas for the copy.
    send_request(CMD_CALLDATA, copy_req(32'd0, 1'b0, 32'd64, 1'b0, 32'd0, 1'b0,
                                        32'd64, 26'(MEM_LIMIT_B), 64'd0));
    // Unaligned current size.
    send_request(CMD_CALLDATA, copy_req(32'd30, 1'b0, 32'd20, 1'b0, 32'd0, 1'b0,
                                        32'd64, 26'd40, GAS_MAX));
    // All fields at their maximum, with and without the huge flags; all zero.
    send_request(CMD_CALLDATA, copy_req(ALL32, 1'b0, ALL32, 1'b0, ALL32, 1'b0,
                                        ALL32, 26'(MEM_LIMIT_B), GAS_MAX));
    send_request(CMD_RETURN_ALIAS, copy_req(ALL32, 1'b1, ALL32, 1'b1, ALL32, 1'b1,
                                            ALL32, 26'(MEM_LIMIT_B), GAS_MAX));
    send_request(CMD_CALLDATA, copy_req(32'd0, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0,
                                        32'd0, 26'd0, 64'd0));

    // Random traffic in phases with different idling on each side.
    send_random(200);
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    send_random(100);
    sender_idle = 1'b1;
    send_random(60);
    sender_idle   = 1'b0;
    receiver_idle = 1'b1;
    send_random(40);
    // Back-to-back requests while the receiver holds off: the pipe fills and
    // the unit must stall its input without losing or reordering anything.
    receiver_idle = 1'b0;
    long_hold_req = 1'b1;
    send_random(40);
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    send_random(60);
    s_axis_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d copy plans: %0d ok, %0d buffer overflow, %0d out of gas,",
             sb.checked, sb.outcome_count[ERR_OK], sb.outcome_count[ERR_BUFFER],
             sb.outcome_count[ERR_GAS]);
    $display("  %0d memory limit, %0d return data out of bounds; input stalled %0d cycles.",
             sb.outcome_count[ERR_MEM_LIMIT], sb.outcome_count[ERR_RETURN_OOB],
             input_stall_cycles);
    if (sb.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
